/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);

  // Field widths of the channels
  localparam int OP_W      = 1;
  localparam int CHAR_W    = 8;
  localparam int CROW_W    = 5;
  localparam int CCOL_W    = 7;
  localparam int ENTRY_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [OP_W-1:0]      OP_WRITE     = 1'b0;
  localparam logic [OP_W-1:0]      OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
  localparam logic [ENTRY_W-1:0]   BLANK_RESET  = 16'h0720;
  localparam logic [COLOR_W-1:0]   COLOR_RESET  = 8'h07;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ENTRY = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK
  } tcw_state_t;

endpackage

/* sv/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: request in, result out
// and register write.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [CROW_W-1:0] cell_row;
  logic [CCOL_W-1:0] cell_column;
  modport source (output valid, operation, char_code, cell_row, cell_column, input ready);
  modport sink   (input valid, operation, char_code, cell_row, cell_column, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] read_entry;
  logic [CROW_W-1:0]  cursor_row;
  logic [CCOL_W-1:0]  cursor_column;
  logic               scrolled;
  modport source (output valid, read_entry, cursor_row, cursor_column, scrolled,
                  input ready);
  modport sink   (input valid, read_entry, cursor_row, cursor_column, scrolled,
                  output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen store of character cells, cursor, newline,
// line wrap and scroll, plus single-cell read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen store to blank entries, one cell a
// cycle; requests are held off meanwhile while register writes are taken at
// once. A character or newline request is then done in the idle state and a
// cell read passes through the address and then the registered read data,
// so a stream of writes runs at one request a cycle if the result is taken.
// A write that moves past the last row scrolls: the single memory port pair
// copies each line below the top up one, one cell a cycle, and then fills the
// bottom line, and the block takes no request until it is done. The
// result of each request sits in an output register; the next request is
// taken in the cycle that result leaves.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic  clk,
  input  logic  rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);
  import tcw_pkg::*;

  // Sequencer and sweep counter
  tcw_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Copy pipeline: read issued last cycle, write lands this cycle
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;

  // Cursor
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;

  // Read request range check, kept for the data cycle
  logic rd_ok_r, rd_ok_nxt;

  // Registers
  logic [COLOR_W-1:0] text_color_r;
  logic [ENTRY_W-1:0] blank_entry_r;

  // Screen store
  logic [ENTRY_W-1:0] mem [CELLS];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] rdata_r;

  // Shared cell address unit: row * COLUMNS + column
  logic [7:0]       mul_row;
  logic [7:0]       mul_col;
  logic [CNT_W-1:0] mul_addr;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0] out_entry_r, out_entry_nxt;
  logic [CROW_W-1:0]  out_row_r, out_row_nxt;
  logic [CCOL_W-1:0]  out_col_r, out_col_nxt;
  logic               out_scr_r, out_scr_nxt;

  logic               load;
  logic [ENTRY_W-1:0] ld_entry;
  logic [ROW_W-1:0]   ld_row;
  logic [COL_W-1:0]   ld_col;
  logic               ld_scr;
  logic [7:0]         ld_row_w;
  logic [7:0]         ld_col_w;

  logic in_ready;
  logic in_acc;
  logic in_range;
  logic wrap;

  // A new request is taken when idle and the output slot is free by the edge
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc   = in_ch.valid && in_ready;

  assign in_range = (9'(in_ch.cell_row) < 9'(ROWS)) && (9'(in_ch.cell_column) < 9'(COLUMNS));

  // Newline forces the wrap; otherwise wrap at the last column
  assign wrap = (in_ch.char_code == NEWLINE_CODE) || (cur_col_r == COL_W'(COLUMNS - 1));

  assign mul_addr = CNT_W'(mul_row) * CNT_W'(COLUMNS) + CNT_W'(mul_col);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = 1'b0;
    dst_nxt     = dst_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    rd_ok_nxt   = rd_ok_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    mul_row     = 8'(cur_row_r);
    mul_col     = 8'(cur_col_r);
    load        = 1'b0;
    ld_entry    = '0;
    ld_row      = cur_row_r;
    ld_col      = cur_col_r;
    ld_scr      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // Post-reset sweep to the reset blank entry
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = BLANK_RESET;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.operation == OP_READ) begin
          mul_row = 8'(in_ch.cell_row);
          mul_col = 8'(in_ch.cell_column);
        end
        mem_raddr = in_range ? mul_addr[ADDR_W-1:0] : '0;
        if (in_acc) begin
          if (in_ch.operation == OP_READ) begin
            rd_ok_nxt = in_range;
            state_nxt = ST_READ;
          end else begin
            if (in_ch.char_code != NEWLINE_CODE) begin
              mem_we    = 1'b1;
              mem_waddr = mul_addr[ADDR_W-1:0];
              mem_wdata = {text_color_r, in_ch.char_code};
            end
            if (!wrap) begin
              cur_col_nxt = cur_col_r + 1'b1;
            end else begin
              cur_col_nxt = '0;
              if (cur_row_r != ROW_W'(ROWS - 1)) begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end
            if (wrap && (cur_row_r == ROW_W'(ROWS - 1))) begin
              // Past the last row: scroll, cursor stays on the last row
              cnt_nxt   = CNT_W'(COLUMNS);
              state_nxt = ST_COPY;
            end else begin
              load   = 1'b1;
              ld_row = cur_row_nxt;
              ld_col = cur_col_nxt;
            end
          end
        end
      end

      ST_READ: begin
        load      = 1'b1;
        ld_entry  = rd_ok_r ? rdata_r : '0;
        state_nxt = ST_IDLE;
      end

      ST_COPY: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = rdata_r;
        end
        if (cnt_r != CNT_W'(CELLS)) begin
          mem_raddr = cnt_r[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          dst_nxt   = ADDR_W'(cnt_r - CNT_W'(COLUMNS));
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = CNT_W'(CELLS - COLUMNS);
          state_nxt = ST_BLANK;
        end
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = blank_entry_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          load      = 1'b1;
          ld_scr    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register; cursor fields are masked to the port widths
  assign ld_row_w = 8'(ld_row);
  assign ld_col_w = 8'(ld_col);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_entry_nxt = out_entry_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_entry_nxt = ld_entry;
      out_row_nxt   = ld_row_w[CROW_W-1:0];
      out_col_nxt   = ld_col_w[CCOL_W-1:0];
      out_scr_nxt   = ld_scr;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r       <= dst_nxt;
    out_entry_r <= out_entry_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  // Register writes, always accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= COLOR_RESET;
      blank_entry_r <= BLANK_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TEXT_COLOR:  text_color_r  <= cfg_ch.data[COLOR_W-1:0];
        CFG_BLANK_ENTRY: blank_entry_r <= cfg_ch.data[ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign cfg_ch.ready         = 1'b1;
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_entry    = out_entry_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.scrolled      = out_scr_r;

endmodule

/* sv/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::ENTRY_W-1:0]   out_read_entry,
  input logic [tcw_pkg::CROW_W-1:0]    out_cursor_row,
  input logic [tcw_pkg::CCOL_W-1:0]    out_cursor_column,
  input logic                          out_scrolled
);
  import tcw_pkg::*;

  // Store is being cleared right after reset: no request taken
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request accepted during post-reset clear");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_entry)
      && $stable(out_cursor_row) && $stable(out_cursor_column) && $stable(out_scrolled))
    else $error("result changed while stalled");

  // Cursor reported inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (9'(out_cursor_row) < 9'(ROWS)) && (9'(out_cursor_column) < 9'(COLUMNS)))
    else $error("cursor outside screen");

  // A scroll leaves the cursor at the start of the bottom line, no read data
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (9'(out_cursor_row) == 9'(ROWS - 1))
      && (out_cursor_column == '0) && (out_read_entry == '0))
    else $error("scroll result with wrong cursor");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_read_entry    (out_ch.read_entry),
  .out_cursor_row    (out_ch.cursor_row),
  .out_cursor_column (out_ch.cursor_column),
  .out_scrolled      (out_ch.scrolled)
);
